@@ rtl/hq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and state codes of the histogram equalizer.
package hq_pkg;

  localparam int COUNT_BITS = 22;
  localparam int NUM_BINS   = 256;
  localparam int BIN_BITS   = $clog2(NUM_BINS);
  localparam int PIX_BITS   = 8;
  localparam int QUO_BITS   = 8;
  localparam int STEP_BITS  = $clog2(QUO_BITS);
  localparam int SUM_BITS   = COUNT_BITS + BIN_BITS;
  localparam int PROD_BITS  = SUM_BITS + QUO_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [PIX_BITS-1:0]   pix_t;

  localparam count_t COUNT_MAX = '1;
  localparam logic [BIN_BITS-1:0] LAST_BIN = '1;

  localparam logic OP_HIST = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SUM,
    ST_MRD,
    ST_MADD,
    ST_MDIV
  } hq_state_t;

  typedef struct packed {
    logic  start;
    prod_t dividend;
    sum_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/hq_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: pixel beats for the histogram and map passes.
interface hq_in_if import hq_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  pix_t pixel;
  logic last;

  modport source (output valid, output operation, output pixel, output last, input ready);
  modport sink (input valid, input operation, input pixel, input last, output ready);
endinterface

@@ rtl/hq_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: equalized pixel beats.
interface hq_out_if import hq_pkg::*; ();
  logic valid;
  logic ready;
  pix_t equalized_pixel;
  logic last_out;

  modport source (output valid, output equalized_pixel, output last_out, input ready);
  modport sink (input valid, input equalized_pixel, input last_out, output ready);
endinterface

@@ rtl/histogram_equalizer_unit.sv @@
`timescale 1ns / 1ps
// Top level of the two-pass 8-bit grayscale histogram equalizer.
//
//   channel  direction  beat payload
//   item     in         operation, pixel, last
//   result   out        equalized_pixel, last_out (one beat per map item)
//
// Histogram and map beats are taken one per cycle unless a table build or a stalled
// result holds ready low; the bin memory read-modify-write forwards its own last
// write, and a mapped pixel passes the map table read register and then the output
// register. After the last histogram beat the sequencer sums the 256 bins, then
// builds each table entry with the bit-serial divider; ready is low until it is done.
// Reset clears the bin valid flags, so no clearing pass is needed; a new frame
// clears them together on its first histogram beat. A stalled result holds while one more map beat waits.
module histogram_equalizer_unit import hq_pkg::*; (
  input logic clk,
  input logic rst,
  hq_in_if.sink    item,
  hq_out_if.source result
);

  hq_state_t state, state_next;

  logic [BIN_BITS-1:0] cnt;
  logic [NUM_BINS-1:0] bin_vld;
  count_t              bin_mem [NUM_BINS];
  count_t              bin_rdata;
  logic                bin_rvld;
  logic [BIN_BITS-1:0] bin_raddr;
  logic                bin_we;
  count_t              bin_base;
  count_t              bin_wdata;
  count_t              rd_masked;

  pix_t                map_mem [NUM_BINS];
  pix_t                map_rdata;
  logic                map_we;

  logic                s1_valid;
  logic                s1_last;
  pix_t                s1_pixel;
  logic                s1_clear;
  logic                s1_fwd;
  count_t              fwd_data;

  logic                m1_valid;
  logic                m1_last;
  logic                m1_tr;
  logic                o_valid;
  pix_t                o_pixel;
  logic                o_last;
  logic                o_adv;

  logic                table_ready;
  logic                in_map_phase;
  sum_t                sum;
  sum_t                run;
  sum_t                run_next;
  logic                sum_pend;

  logic                accept;
  logic                hist_acc;
  logic                map_acc;
  logic                build_start;
  logic                build_done;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  hq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign o_adv    = !o_valid || result.ready;
  assign accept   = item.valid && item.ready;
  assign hist_acc = accept && (item.operation == OP_HIST);
  assign map_acc  = accept && (item.operation == OP_MAP);

  always_comb begin
    item.ready = (state == ST_RUN) && !(s1_valid && s1_last) && (!m1_valid || o_adv);
  end

  // Bin update: a forwarded value beats the memory, and a new frame reads as empty.
  always_comb begin
    if (s1_fwd) begin
      bin_base = fwd_data;
    end else if (bin_rvld && !s1_clear) begin
      bin_base = bin_rdata;
    end else begin
      bin_base = '0;
    end
    bin_wdata = (bin_base == COUNT_MAX) ? bin_base : bin_base + 1'b1;
    bin_we    = s1_valid;
    rd_masked = bin_rvld ? bin_rdata : '0;
    run_next  = run + SUM_BITS'(rd_masked);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (s1_valid && s1_last) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt == LAST_BIN) begin
          state_next = ST_MRD;
        end
      end
      ST_MRD:  state_next = ST_MADD;
      ST_MADD: state_next = ST_MDIV;
      ST_MDIV: begin
        if (div_rsp.done) begin
          state_next = (cnt == LAST_BIN) ? ST_RUN : ST_MRD;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    bin_raddr        = cnt;
    map_we           = 1'b0;
    div_req.start    = 1'b0;
    build_start      = 1'b0;
    case (state)
      ST_RUN: begin
        bin_raddr   = item.pixel;
        build_start = s1_valid && s1_last;
      end
      ST_MADD: div_req.start = 1'b1;
      ST_MDIV: map_we = div_rsp.done;
      default: ;
    endcase
    build_done       = map_we && (cnt == LAST_BIN);
    div_req.dividend = (PROD_BITS'(run_next) << QUO_BITS) - PROD_BITS'(run_next);
    div_req.divisor  = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      cnt          <= '0;
      bin_vld      <= '0;
      s1_valid     <= 1'b0;
      m1_valid     <= 1'b0;
      o_valid      <= 1'b0;
      table_ready  <= 1'b0;
      in_map_phase <= 1'b0;
      sum_pend     <= 1'b0;
    end else begin
      state    <= state_next;
      sum_pend <= (state == ST_SUM);
      s1_valid <= hist_acc;

      if ((state == ST_SUM) || map_we) begin
        cnt <= cnt + 1'b1;
      end

      if (hist_acc && in_map_phase) begin
        bin_vld      <= '0;
        in_map_phase <= 1'b0;
      end
      if (bin_we) begin
        bin_vld[s1_pixel] <= 1'b1;
      end

      if (build_done) begin
        table_ready  <= 1'b1;
        in_map_phase <= 1'b1;
      end

      if (map_acc) begin
        m1_valid <= 1'b1;
      end else if (o_adv) begin
        m1_valid <= 1'b0;
      end

      if (m1_valid && o_adv) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (hist_acc) begin
      s1_last  <= item.last;
      s1_pixel <= item.pixel;
      s1_clear <= in_map_phase;
      s1_fwd   <= s1_valid && (s1_pixel == item.pixel) && !in_map_phase;
      fwd_data <= bin_wdata;
    end
    if (build_start) begin
      sum <= '0;
      run <= '0;
    end else begin
      if (sum_pend) begin
        sum <= sum + SUM_BITS'(rd_masked);
      end
      if (state == ST_MADD) begin
        run <= run_next;
      end
    end
    if (map_acc) begin
      m1_last <= item.last;
      m1_tr   <= table_ready;
    end
    if (m1_valid && o_adv) begin
      o_pixel <= m1_tr ? map_rdata : '0;
      o_last  <= m1_last;
    end
  end

  // Bin count memory with its valid flag read alongside.
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[s1_pixel] <= bin_wdata;
    end
    bin_rdata <= bin_mem[bin_raddr];
    bin_rvld  <= bin_vld[bin_raddr];
  end

  // Map table memory.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[cnt] <= div_rsp.quotient;
    end
    if (map_acc) begin
      map_rdata <= map_mem[item.pixel];
    end
  end

  assign result.valid           = o_valid;
  assign result.equalized_pixel = o_pixel;
  assign result.last_out        = o_last;

`ifndef SYNTHESIS
  a_build_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (hist_acc && item.last) |=> !item.ready)
    else $error("input taken right after the last histogram beat");

  a_result_from_map_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(m1_valid))
    else $error("result beat without a map item behind it");

  a_no_update_in_build: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !s1_valid)
    else $error("bin update pending while the table is being built");

  a_fwd_same_frame: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd) |-> !s1_clear)
    else $error("forwarded count crosses a frame boundary");
`endif

endmodule

@@ rtl/hq_div.sv @@
`timescale 1ns / 1ps
// Restoring divider that yields an 8-bit quotient, one bit per cycle.
module hq_div import hq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [STEP_BITS-1:0] step;
  prod_t                rem;
  prod_t                dsh;
  logic [QUO_BITS-1:0]  quo;
  logic                 ge;

  // The dividend is below 256 times the divisor, so eight quotient bits suffice.
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(QUO_BITS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsh <= PROD_BITS'(req.divisor) << (QUO_BITS - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_BITS-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ tb/sv/histogram_equalizer_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the two-pass histogram equalizer with its own pixel map predictor.
module histogram_equalizer_unit_tb;
  import hq_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int QUIET_TAIL   = 250;
  localparam int BUILD_CYCLES = 3200;
  localparam int MAX_PRINTED  = 40;
  localparam int PIX_FULL     = 255;

  typedef struct packed {
    logic op;
    pix_t px;
    logic lst;
  } pix_beat_t;

  typedef struct packed {
    pix_t value;
    logic lst;
  } mapped_beat_t;

  logic clk;
  logic rst;

  hq_in_if  item_bus ();
  hq_out_if result_bus ();

  histogram_equalizer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  // Predictor state: one frame of bin counts and the last map built from them.
  count_t hist_bins [NUM_BINS];
  pix_t   eq_lut [NUM_BINS];
  count_t frame_total;
  logic   lut_valid;
  logic   map_phase;

  pix_beat_t    pending_beats [$];
  mapped_beat_t expected_pixels [$];

  int     beats_total;
  int     hist_beats;
  int     map_beats;
  int     luts_built;
  int     beats_taken;
  int     results_checked;
  int     mismatch_count;
  longint cycle_count;
  longint cycle_limit;
  logic   in_fire_q;
  int     send_gap;
  int     recv_gap;
  int     send_idle_pct;
  int     recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic count_t bump_count(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void rebuild_lut();
    sum_t  bin_sum;
    sum_t  running;
    prod_t scaled;
    bin_sum = '0;
    for (int v = 0; v < NUM_BINS; v++) bin_sum += sum_t'(hist_bins[v]);
    running = '0;
    for (int v = 0; v < NUM_BINS; v++) begin
      running += sum_t'(hist_bins[v]);
      scaled = prod_t'(running) * prod_t'(PIX_FULL);
      eq_lut[v] = (bin_sum == '0) ? '0 : pix_t'(scaled / prod_t'(bin_sum));
    end
    lut_valid = 1'b1;
    map_phase = 1'b1;
  endfunction

  task automatic predict_beat(input pix_beat_t b);
    mapped_beat_t e;
    if (b.op == OP_HIST) begin
      // The first histogram beat after a map was built starts a new frame.
      if (map_phase) begin
        for (int v = 0; v < NUM_BINS; v++) hist_bins[v] = '0;
        frame_total = '0;
        map_phase = 1'b0;
      end
      hist_bins[b.px] = bump_count(hist_bins[b.px]);
      frame_total = bump_count(frame_total);
      if (b.lst) rebuild_lut();
    end else begin
      e.value = lut_valid ? eq_lut[b.px] : '0;
      e.lst = b.lst;
      expected_pixels.push_back(e);
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  task automatic queue_beat(input logic op, input int px, input logic lst);
    pix_beat_t b;
    b.op = op;
    b.px = pix_t'(px);
    b.lst = lst;
    pending_beats.push_back(b);
    beats_total++;
    if (op == OP_HIST) begin
      hist_beats++;
      if (lst) luts_built++;
    end else begin
      map_beats++;
    end
  endtask

  function automatic pix_t draw_pixel(int style, int centre, int spread);
    int v;
    case (style)
      0: v = int'($urandom_range(255, 0));
      1: v = centre + int'($urandom_range(2 * spread, 0)) - spread;
      2: v = ($urandom_range(1, 0) ? centre : PIX_FULL - centre) + int'($urandom_range(3, 0));
      default: v = centre;
    endcase
    if (v < 0) v = 0;
    if (v > PIX_FULL) v = PIX_FULL;
    return pix_t'(v);
  endfunction

  // Most passes are short so that many maps get built; a few are long.
  function automatic int draw_len();
    return ($urandom_range(19, 0) == 0) ? int'($urandom_range(400, 49))
                                        : int'($urandom_range(48, 1));
  endfunction

  task automatic queue_random_frame();
    int kind;
    int style;
    int centre;
    int spread;
    int n;
    kind = $urandom_range(99, 0);
    style = $urandom_range(3, 0);
    centre = $urandom_range(255, 0);
    spread = $urandom_range(20, 1);
    if (kind < 80) begin
      n = draw_len();
      for (int i = 0; i < n; i++) begin
        // Some frames slip map beats into the histogram pass; they read the old map.
        if (kind >= 65 && $urandom_range(7, 0) == 0)
          queue_beat(OP_MAP, $urandom_range(255, 0), 1'($urandom_range(1, 0)));
        queue_beat(OP_HIST, int'(draw_pixel(style, centre, spread)), i == n - 1);
      end
      n = draw_len();
      for (int i = 0; i < n; i++)
        queue_beat(OP_MAP, $urandom_range(1, 0) ? int'(draw_pixel(0, 0, 0))
                                                : int'(draw_pixel(style, centre, spread)),
                   i == n - 1);
    end else if (kind < 90) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++)
        queue_beat(OP_MAP, $urandom_range(255, 0), 1'($urandom_range(1, 0)));
    end else begin
      // Broken frames: last flags land anywhere in the histogram pass.
      n = $urandom_range(16, 1);
      for (int i = 0; i < n; i++)
        queue_beat(OP_HIST, int'(draw_pixel(style, centre, spread)),
                   $urandom_range(3, 0) == 0);
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
        queue_beat(OP_MAP, $urandom_range(255, 0), 1'($urandom_range(1, 0)));
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 6;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic bit in_tail();
    return pending_beats.size() < QUIET_TAIL;
  endfunction

  always @(negedge clk) begin : feed_items
    pix_beat_t beat;
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || in_fire_q) begin
      if (send_gap != 0) begin
        send_gap--;
        item_bus.valid <= 1'b0;
      end else if (pending_beats.size() != 0 && !in_tail()
                   && $urandom_range(99, 0) < send_idle_pct) begin
        send_gap = $urandom_range(16, 1) - 1;
        item_bus.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        beat = pending_beats.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.operation <= beat.op;
        item_bus.pixel <= beat.px;
        item_bus.last <= beat.lst;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
    if ($urandom_range(199, 0) == 0) send_idle_pct = pick_idle_pct();
  end

  always @(negedge clk) begin
    if (recv_gap != 0) begin
      recv_gap--;
      result_bus.ready <= 1'b0;
    end else if (!in_tail() && $urandom_range(99, 0) < recv_idle_pct) begin
      recv_gap = $urandom_range(16, 1) - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
    if ($urandom_range(199, 0) == 0) recv_idle_pct = pick_idle_pct();
  end

  always @(posedge clk) begin : watch_beats
    pix_beat_t    taken;
    mapped_beat_t want;
    cycle_count++;
    in_fire_q = !rst && item_bus.valid && item_bus.ready;
    if (in_fire_q) begin
      taken.op = item_bus.operation;
      taken.px = item_bus.pixel;
      taken.lst = item_bus.last;
      predict_beat(taken);
      beats_taken++;
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("result beat pixel %0d with none expected",
                                result_bus.equalized_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (result_bus.equalized_pixel !== want.value)
          flag_mismatch($sformatf("result %0d: equalized_pixel %0d, expected %0d",
                                  results_checked, result_bus.equalized_pixel, want.value));
        if (result_bus.last_out !== want.lst)
          flag_mismatch($sformatf("result %0d: last_out %0b, expected %0b",
                                  results_checked, result_bus.last_out, want.lst));
        results_checked++;
      end
    end
  end

  initial begin
    wait (cycle_limit != 0);
    while (cycle_count < cycle_limit) @(negedge clk);
    $display("Timed out after %0d cycles with %0d of %0d beats taken.",
             cycle_count, beats_taken, beats_total);
    $display("[histogram_equalizer_unit] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_HIST;
    item_bus.pixel = '0;
    item_bus.last = 1'b0;
    result_bus.ready = 1'b0;
    for (int v = 0; v < NUM_BINS; v++) begin
      hist_bins[v] = '0;
      eq_lut[v] = '0;
    end
    frame_total = '0;
    lut_valid = 1'b0;
    map_phase = 1'b0;
    beats_total = 0;
    hist_beats = 0;
    map_beats = 0;
    luts_built = 0;
    beats_taken = 0;
    results_checked = 0;
    mismatch_count = 0;
    cycle_count = 0;
    cycle_limit = 0;
    in_fire_q = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    // Map beats before any map exists return zero, even after histogram beats.
    queue_beat(OP_MAP, 0, 1'b0);
    queue_beat(OP_MAP, 255, 1'b1);
    queue_beat(OP_HIST, 0, 1'b0);
    queue_beat(OP_MAP, 128, 1'b0);
    queue_beat(OP_HIST, 255, 1'b0);
    queue_beat(OP_HIST, 255, 1'b1);
    queue_beat(OP_MAP, 0, 1'b0);
    queue_beat(OP_MAP, 254, 1'b0);
    queue_beat(OP_MAP, 255, 1'b1);
    // A new frame starts; the old map stays in use until the next one is built.
    queue_beat(OP_HIST, 7, 1'b0);
    queue_beat(OP_MAP, 255, 1'b0);
    queue_beat(OP_MAP, 0, 1'b1);
    queue_beat(OP_HIST, 7, 1'b1);
    queue_beat(OP_MAP, 0, 1'b0);
    queue_beat(OP_MAP, 6, 1'b0);
    queue_beat(OP_MAP, 7, 1'b0);
    queue_beat(OP_MAP, 255, 1'b1);
    // A one-beat frame on pixel zero maps everything to full scale.
    queue_beat(OP_HIST, 0, 1'b1);
    queue_beat(OP_MAP, 0, 1'b0);
    queue_beat(OP_MAP, 170, 1'b1);
    queue_beat(OP_HIST, 85, 1'b0);
    queue_beat(OP_HIST, 170, 1'b0);
    queue_beat(OP_HIST, 170, 1'b1);
    queue_beat(OP_MAP, 85, 1'b0);
    queue_beat(OP_MAP, 169, 1'b1);

    while (beats_total < 25 + RANDOM_BEATS) queue_random_frame();
    // Close on a full frame so the tail ends with results in flight.
    for (int i = 0; i < 20; i++) queue_beat(OP_HIST, $urandom_range(255, 0), i == 19);
    for (int i = 0; i < 20; i++) queue_beat(OP_MAP, $urandom_range(255, 0), i == 19);

    cycle_limit = 4 * (longint'(luts_built) * BUILD_CYCLES + longint'(beats_total) * 40) + 20000;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (beats_taken < beats_total) @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (BUILD_CYCLES) @(negedge clk);

    if (expected_pixels.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_pixels.size()));
    $display("Sent %0d histogram and %0d map beats, building %0d pixel maps.",
             hist_beats, map_beats, luts_built);
    $display("Checked %0d equalized result beats; %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[histogram_equalizer_unit] OK");
    end else begin
      $display("[histogram_equalizer_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hq_pkg.sv
rtl/hq_in_if.sv
rtl/hq_out_if.sv
rtl/hq_div.sv
rtl/histogram_equalizer_unit.sv
tb/sv/histogram_equalizer_unit_tb.sv
